// ===== rtl/rational_arithmetic_unit_macros.svh =====
// Assertion helpers, sampled on clock and disabled in reset.
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// same-cycle implication
`define RAU_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define RAU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/rau_pkg.sv =====
`timescale 1ns / 1ps
package rau_pkg;

   localparam int RES_NUM_W = 32;
   localparam int RES_DEN_W = 31;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_CMP = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK  = 2'd0,
      STAT_ERR = 2'd1,
      STAT_OVF = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ORD_LT = 2'd0,
      ORD_EQ = 2'd1,
      ORD_GT = 2'd2
   } order_type;

   typedef struct packed {
      op_type op;
      logic   err;
      logic   sa;
      logic   sb;
   } rau_ctrl_type;

   typedef struct packed {
      logic [RES_NUM_W-1:0] res_num;
      logic [RES_DEN_W-1:0] res_den;
      order_type            order;
      status_type           status;
   } rau_result_type;

endpackage

// ===== rtl/rau_fifo.sv =====
`timescale 1ns / 1ps
module rau_fifo #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] din,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] dout,
   output logic              empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ff;
   logic [PTR_W-1:0]  rd_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              do_push;
   logic              do_pop;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
      end
   end
endmodule

// ===== rtl/rau_front.sv =====
`timescale 1ns / 1ps
module rau_front #(
   parameter int W = 32
) (
   input  logic [2:0]            req_func,
   input  logic [31:0]           req_a_num,
   input  logic [31:0]           req_a_den,
   input  logic [31:0]           req_b_num,
   input  logic [31:0]           req_b_den,
   output rau_pkg::rau_ctrl_type ctrl,
   output logic [4*W-1:0]        mags
);
   import rau_pkg::*;

   logic [W-1:0] ma, da, mb, db;
   logic         n_an, n_ad, n_bn, n_bd;
   logic         bad_func;

   function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
      return v[W-1] ? (~v) + W'(1) : v;
   endfunction

   always_comb begin
      n_an = req_a_num[W-1];
      n_ad = req_a_den[W-1];
      n_bn = req_b_num[W-1];
      n_bd = req_b_den[W-1];
      ma   = mag_of(req_a_num[W-1:0]);
      da   = mag_of(req_a_den[W-1:0]);
      mb   = mag_of(req_b_num[W-1:0]);
      db   = mag_of(req_b_den[W-1:0]);
      bad_func = (req_func > 3'(OP_CMP));
      ctrl.op  = bad_func ? OP_ADD : op_type'(req_func);
      ctrl.sa  = n_an ^ n_ad;
      ctrl.sb  = n_bn ^ n_bd;
      ctrl.err = bad_func || (da == '0) || (db == '0)
                 || ((req_func == 3'(OP_DIV)) && (mb == '0));
      mags = {ma, da, mb, db};
   end
endmodule

// ===== rtl/rau_back.sv =====
`timescale 1ns / 1ps
module rau_back #(
   parameter int W = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   input  rau_pkg::rau_ctrl_type   q_ctrl,
   input  logic [4*W-1:0]          q_mags,
   output logic                    q_pop,
   input  logic                    out_full,
   output logic                    out_push,
   output rau_pkg::rau_result_type out_res
);
   import rau_pkg::*;
   `include "rational_arithmetic_unit_macros.svh"

   localparam int PW    = 2 * W;
   localparam int SH_W  = $clog2(PW);
   localparam logic [PW-1:0] LIM = PW'(1) << (W - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_SUM, S_GSH, S_GX, S_GY, S_DIV, S_CHECK, S_OUT
   } state_type;

   state_type      state_ff;
   rau_ctrl_type   ctrl_ff;
   logic [W-1:0]   ma_ff, da_ff, mb_ff, db_ff;
   logic [PW-1:0]  p1_ff, p2_ff, p3_ff;
   logic [PW-1:0]  x_ff, y_ff, g_ff;
   logic [SH_W-1:0] sh_ff;
   logic [SH_W-1:0] cnt_ff;
   logic [PW-1:0]  nn_ff, nd_ff, rn_ff, rdm_ff;
   logic           rs_ff;
   rau_result_type res_ff;

   logic [W-1:0]   mul_a, mul_b;
   logic [PW-1:0]  prod;
   logic           s2;
   logic [PW-1:0]  sum_rm;
   logic           sum_rs;
   order_type      cmp_ord;
   logic           ca, cb;
   logic [PW:0]    tn, td;
   logic           qn, qd;
   logic [31:0]    num32;

   assign q_pop    = (state_ff == S_IDLE) && !q_empty;
   assign out_push = (state_ff == S_OUT) && !out_full;
   assign out_res  = res_ff;

   always_comb begin
      unique case (state_ff)
         S_MUL0: begin
            mul_a = ma_ff;
            mul_b = (ctrl_ff.op == OP_MUL) ? mb_ff : db_ff;
         end
         S_MUL1: begin
            mul_a = mb_ff;
            mul_b = da_ff;
         end
         default: begin
            mul_a = da_ff;
            mul_b = (ctrl_ff.op == OP_DIV) ? mb_ff : db_ff;
         end
      endcase
      prod = mul_a * mul_b;
   end

   always_comb begin
      s2 = (ctrl_ff.op == OP_SUB) ? !ctrl_ff.sb : ctrl_ff.sb;
      if (ctrl_ff.op == OP_MUL || ctrl_ff.op == OP_DIV) begin
         sum_rm = p1_ff;
         sum_rs = ctrl_ff.sa ^ ctrl_ff.sb;
      end else if (ctrl_ff.sa == s2) begin
         sum_rm = p1_ff + p2_ff;
         sum_rs = ctrl_ff.sa;
      end else if (p1_ff >= p2_ff) begin
         sum_rm = p1_ff - p2_ff;
         sum_rs = ctrl_ff.sa;
      end else begin
         sum_rm = p2_ff - p1_ff;
         sum_rs = s2;
      end
      ca = ctrl_ff.sa && (p1_ff != '0);
      cb = ctrl_ff.sb && (p2_ff != '0);
      if (ca != cb) begin
         cmp_ord = ca ? ORD_LT : ORD_GT;
      end else if (p1_ff == p2_ff) begin
         cmp_ord = ORD_EQ;
      end else if (!ca) begin
         cmp_ord = (p1_ff < p2_ff) ? ORD_LT : ORD_GT;
      end else begin
         cmp_ord = (p1_ff < p2_ff) ? ORD_GT : ORD_LT;
      end
   end

   always_comb begin
      tn = {rn_ff, nn_ff[PW-1]};
      td = {rdm_ff, nd_ff[PW-1]};
      qn = (tn >= {1'b0, g_ff});
      qd = (td >= {1'b0, g_ff});
      num32 = rs_ff ? (32'd0 - 32'(nn_ff)) : 32'(nn_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (!q_empty) begin
                  ctrl_ff <= q_ctrl;
                  {ma_ff, da_ff, mb_ff, db_ff} <= q_mags;
                  if (q_ctrl.err) begin
                     res_ff   <= '{res_num: '0, res_den: '0, order: ORD_LT, status: STAT_ERR};
                     state_ff <= S_OUT;
                  end else begin
                     state_ff <= S_MUL0;
                  end
               end
            end
            S_MUL0: begin
               p1_ff    <= prod;
               state_ff <= S_MUL1;
            end
            S_MUL1: begin
               p2_ff    <= prod;
               state_ff <= S_MUL2;
            end
            S_MUL2: begin
               p3_ff    <= prod;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               if (ctrl_ff.op == OP_CMP) begin
                  res_ff   <= '{res_num: '0, res_den: '0, order: cmp_ord, status: STAT_OK};
                  state_ff <= S_OUT;
               end else if (sum_rm == '0) begin
                  nn_ff    <= '0;
                  nd_ff    <= PW'(1);
                  rs_ff    <= 1'b0;
                  state_ff <= S_CHECK;
               end else begin
                  nn_ff    <= sum_rm;
                  nd_ff    <= p3_ff;
                  rs_ff    <= sum_rs;
                  x_ff     <= sum_rm;
                  y_ff     <= p3_ff;
                  sh_ff    <= '0;
                  state_ff <= S_GSH;
               end
            end
            S_GSH: begin
               if (!(x_ff[0] || y_ff[0])) begin
                  x_ff  <= x_ff >> 1;
                  y_ff  <= y_ff >> 1;
                  sh_ff <= sh_ff + SH_W'(1);
               end else begin
                  state_ff <= S_GX;
               end
            end
            S_GX: begin
               if (!x_ff[0]) begin
                  x_ff <= x_ff >> 1;
               end else begin
                  state_ff <= S_GY;
               end
            end
            S_GY: begin
               priority if (y_ff == '0) begin
                  g_ff     <= x_ff << sh_ff;
                  rn_ff    <= '0;
                  rdm_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= S_DIV;
               end else if (!y_ff[0]) begin
                  y_ff <= y_ff >> 1;
               end else if (x_ff > y_ff) begin
                  x_ff <= y_ff;
                  y_ff <= x_ff - y_ff;
               end else begin
                  y_ff <= y_ff - x_ff;
               end
            end
            S_DIV: begin
               rn_ff  <= qn ? PW'(tn - {1'b0, g_ff}) : PW'(tn);
               rdm_ff <= qd ? PW'(td - {1'b0, g_ff}) : PW'(td);
               nn_ff  <= {nn_ff[PW-2:0], qn};
               nd_ff  <= {nd_ff[PW-2:0], qd};
               cnt_ff <= cnt_ff + SH_W'(1);
               if (cnt_ff == SH_W'(PW - 1)) begin
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if ((nd_ff >= LIM) || (!rs_ff && nn_ff >= LIM) || (rs_ff && nn_ff > LIM)) begin
                  res_ff <= '{res_num: '0, res_den: '0, order: ORD_LT, status: STAT_OVF};
               end else begin
                  res_ff <= '{res_num: num32, res_den: RES_DEN_W'(nd_ff),
                              order: ORD_LT, status: STAT_OK};
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!out_full) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // odd part of the gcd stays odd while reducing
   `RAU_ASSERT_NOW(a_gcd_odd, state_ff == S_GY, x_ff[0])
   // division by the gcd is exact
   `RAU_ASSERT_NEXT(a_exact, state_ff == S_DIV && cnt_ff == SH_W'(PW - 1), rn_ff == '0 && rdm_ff == '0)
   `RAU_ASSERT_NOW(a_den_pos, out_push && res_ff.status == STAT_OK && ctrl_ff.op != OP_CMP, res_ff.res_den != '0)
   `RAU_ASSERT_NEXT(a_pop_busy, q_pop, state_ff != S_IDLE)
endmodule

// ===== rtl/rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// Sequence: errors go straight to the output; compares finish after the three multiplies and
// the sum; other arithmetic adds a binary GCD reduction (shifts and subtracts) and an exact
// division by the GCD, which a zero arithmetic result skips, before the overflow check.
// Back end: one item at a time; the GCD loop and the 2*OPERAND_WIDTH-step exact divider
// take most of its time per item.
// Two-entry queues buffer requests and results.
// Reset: synchronous, active high; empties both queues and idles the sequencer.
module rational_arithmetic_unit #(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_func,
   input  logic [31:0] req_a_num,
   input  logic [31:0] req_a_den,
   input  logic [31:0] req_b_num,
   input  logic [31:0] req_b_den,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic [31:0] rsp_res_num,
   output logic [30:0] rsp_res_den,
   output logic [1:0]  rsp_order,
   output logic [1:0]  rsp_status
);
   import rau_pkg::*;

   localparam int W      = OPERAND_WIDTH;
   localparam int CTRL_W = $bits(rau_ctrl_type);
   localparam int QW     = CTRL_W + 4 * W;
   localparam int RW     = $bits(rau_result_type);

   rau_ctrl_type   f_ctrl;
   logic [4*W-1:0] f_mags;
   logic [QW-1:0]  q_dout;
   logic           q_empty;
   logic           q_pop;
   logic           out_full;
   logic           out_push;
   rau_result_type b_res;
   logic [RW-1:0]  o_dout;
   rau_result_type o_res;

   rau_front #(.W(W)) u_front (
      .req_func  (req_func),
      .req_a_num (req_a_num),
      .req_a_den (req_a_den),
      .req_b_num (req_b_num),
      .req_b_den (req_b_den),
      .ctrl      (f_ctrl),
      .mags      (f_mags)
   );

   rau_fifo #(.DATA_W(QW), .DEPTH(2)) u_req_q (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .din   ({f_ctrl, f_mags}),
      .full  (req_full),
      .pop   (q_pop),
      .dout  (q_dout),
      .empty (q_empty)
   );

   rau_back #(.W(W)) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_ctrl   (rau_ctrl_type'(q_dout[QW-1 -: CTRL_W])),
      .q_mags   (q_dout[4*W-1:0]),
      .q_pop    (q_pop),
      .out_full (out_full),
      .out_push (out_push),
      .out_res  (b_res)
   );

   rau_fifo #(.DATA_W(RW), .DEPTH(2)) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .din   (b_res),
      .full  (out_full),
      .pop   (rsp_pop),
      .dout  (o_dout),
      .empty (rsp_empty)
   );

   assign o_res       = rau_result_type'(o_dout);
   assign rsp_res_num = o_res.res_num;
   assign rsp_res_den = o_res.res_den;
   assign rsp_order   = o_res.order;
   assign rsp_status  = o_res.status;
endmodule

// ===== test/rau_checker.sv =====
`timescale 1ns / 1ps
module rau_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [2:0]  req_func,
   input  logic [31:0] req_a_num,
   input  logic [31:0] req_a_den,
   input  logic [31:0] req_b_num,
   input  logic [31:0] req_b_den,
   input  logic        rsp_pop,
   input  logic        rsp_empty,
   input  logic [31:0] rsp_res_num,
   input  logic [30:0] rsp_res_den,
   input  logic [1:0]  rsp_order,
   input  logic [1:0]  rsp_status,
   output int          errors,
   output int          pending,
   output int          results_seen
);
   import rau_pkg::*;

   rau_result_type fraction_q[$];

   function automatic logic [63:0] magnitude(input logic [31:0] v, output logic neg);
      neg = v[31];
      return neg ? {32'd0, ~v + 32'd1} : {32'd0, v};
   endfunction

   function automatic logic [63:0] binary_gcd(input logic [63:0] x, input logic [63:0] y);
      int sh;
      logic [63:0] t;
      sh = 0;
      if (x == 0) return y;
      if (y == 0) return x;
      while (((x | y) & 1) == 0) begin
         x = x >> 1;
         y = y >> 1;
         sh++;
      end
      while (x[0] == 0) x = x >> 1;
      while (y != 0) begin
         while (y[0] == 0) y = y >> 1;
         if (x > y) begin
            t = x;
            x = y;
            y = t;
         end
         y = y - x;
      end
      return x << sh;
   endfunction

   function automatic rau_result_type fraction_result(input logic [2:0] f,
         input logic [31:0] an, input logic [31:0] ad,
         input logic [31:0] bn, input logic [31:0] bd);
      rau_result_type r;
      logic nan, nad, nbn, nbd, sa, sb, s2, rs;
      logic [63:0] ma, da, mb, db, t1, t2, rm, rd, g;
      r = '0;
      r.order = ORD_LT;
      r.status = STAT_OK;
      ma = magnitude(an, nan);
      da = magnitude(ad, nad);
      mb = magnitude(bn, nbn);
      db = magnitude(bd, nbd);
      sa = nan != nad;
      sb = nbn != nbd;
      rs = 0;
      if (f > OP_CMP || da == 0 || db == 0 || (f == OP_DIV && mb == 0)) begin
         r.status = STAT_ERR;
         return r;
      end
      t1 = ma * db;
      t2 = mb * da;
      rd = da * db;
      case (f)
         OP_ADD, OP_SUB: begin
            s2 = (f == OP_SUB) ? !sb : sb;
            if (sa == s2) begin
               rm = t1 + t2;
               rs = sa;
            end else if (t1 >= t2) begin
               rm = t1 - t2;
               rs = sa;
            end else begin
               rm = t2 - t1;
               rs = s2;
            end
         end
         OP_MUL: begin
            rm = ma * mb;
            rs = sa != sb;
         end
         OP_DIV: begin
            rm = t1;
            rd = t2;
            rs = sa != sb;
         end
         default: begin
            if (t1 == 0) sa = 0;
            if (t2 == 0) sb = 0;
            if (sa != sb) r.order = sa ? ORD_LT : ORD_GT;
            else if (t1 == t2) r.order = ORD_EQ;
            else if (!sa) r.order = (t1 < t2) ? ORD_LT : ORD_GT;
            else r.order = (t1 < t2) ? ORD_GT : ORD_LT;
            return r;
         end
      endcase
      if (rm == 0) begin
         rd = 1;
         rs = 0;
      end else begin
         g = binary_gcd(rm, rd);
         rm = rm / g;
         rd = rd / g;
      end
      if (rd > 64'h7fff_ffff || (!rs && rm > 64'h7fff_ffff) || (rs && rm > 64'h8000_0000)) begin
         r.status = STAT_OVF;
         return r;
      end
      r.res_num = rs ? 32'(-rm) : 32'(rm);
      r.res_den = rd[30:0];
      return r;
   endfunction

   always @(posedge clock) begin
      rau_result_type want;
      if (reset) begin
         errors <= 0;
         results_seen <= 0;
         pending <= 0;
         fraction_q.delete();
      end else begin
         if (req_push && !req_full)
            fraction_q.push_back(fraction_result(req_func, req_a_num, req_a_den,
                                                 req_b_num, req_b_den));
         if (rsp_pop && !rsp_empty) begin
            results_seen <= results_seen + 1;
            if (fraction_q.size() == 0) begin
               errors <= errors + 1;
               if (errors < 10) $display("unexpected result num=%h", rsp_res_num);
            end else begin
               want = fraction_q.pop_front();
               if (want.res_num !== rsp_res_num || want.res_den !== rsp_res_den ||
                   want.order !== rsp_order || want.status !== rsp_status) begin
                  errors <= errors + 1;
                  if (errors < 10)
                     $display("mismatch: exp %h/%h ord %0d st %0d, got %h/%h ord %0d st %0d",
                        want.res_num, want.res_den, want.order, want.status,
                        rsp_res_num, rsp_res_den, rsp_order, rsp_status);
               end
            end
         end
         pending <= fraction_q.size();
      end
   end

endmodule

// ===== test/tb_rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps
module tb_rational_arithmetic_unit;
   import rau_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_push = 0;
   logic        req_full;
   logic [2:0]  req_func = OP_ADD;
   logic [31:0] req_a_num = 0, req_a_den = 1, req_b_num = 0, req_b_den = 1;
   logic        rsp_pop = 0;
   logic        rsp_empty;
   logic [31:0] rsp_res_num;
   logic [30:0] rsp_res_den;
   logic [1:0]  rsp_order, rsp_status;
   int          errors, pending, results_seen;
   int          items_sent = 0;
   bit          steady = 0;

   rational_arithmetic_unit i_dut (.*);
   rau_checker i_checker (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 0;
         3: return 32'($signed($urandom_range(0, 8)) - 4);
         4: return $urandom_range(1, 1000) * (($urandom_range(0, 5) + 1) * 6);
         5: return -($urandom_range(1, 1000) * 12);
         6: return 32'($signed($urandom_range(0, 200)) - 100);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_item(input logic [2:0] f, input logic [31:0] an, input logic [31:0] ad,
                            input logic [31:0] bn, input logic [31:0] bd);
      while (!steady && $urandom_range(0, 99) < 25) begin
         req_push <= 0;
         @(negedge clock);
      end
      req_push <= 1;
      req_func <= f;
      req_a_num <= an;
      req_a_den <= ad;
      req_b_num <= bn;
      req_b_den <= bd;
      @(posedge clock);
      while (req_full) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   always @(negedge clock) begin
      rsp_pop <= steady ? 1'b1 : ($urandom_range(0, 99) >= 25);
   end

   initial begin
      logic [31:0] edge_vals[6];
      logic [2:0] f;
      edge_vals = '{32'h8000_0000, 32'h7fff_ffff, 0, 1, 32'hffff_ffff, 32'h0001_0000};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      for (int k = 0; k < 8; k++) send_item(k[2:0], 3, 4, -5, 6);
      send_item(OP_ADD, 1, 0, 1, 1);
      send_item(OP_CMP, 1, 1, 1, 0);
      send_item(OP_DIV, 1, 2, 0, -3);
      send_item(OP_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1);
      send_item(OP_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
      send_item(OP_DIV, 32'h8000_0000, 1, -1, 1);
      send_item(OP_SUB, 2, 4, 1, 2);
      send_item(OP_CMP, 2, 4, -1, -2);
      send_item(OP_CMP, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
      send_item(OP_MUL, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000);
      send_item(OP_ADD, 0, -7, 0, 3);
      for (int k = 0; k < 6; k++)
         send_item(3'(k % 5), edge_vals[k], edge_vals[(k + 1) % 6] | 1,
                   edge_vals[(k + 2) % 6], edge_vals[(k + 3) % 6] | 2);
      req_push <= 0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      for (int n = 0; n < 950; n++) begin
         steady = (n >= 400 && n < 520);
         f = ($urandom_range(0, 30) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
         send_item(f, pick_value(), pick_value() | ($urandom_range(0, 15) != 0),
                   pick_value(), pick_value() | ($urandom_range(0, 15) != 0));
      end
      req_push <= 0;
      steady = 0;
      fork
         while (pending != 0) @(negedge clock);
         begin
            #15_000_000;
         end
      join_any
      repeat (400) @(negedge clock);
      $display("Sent %0d items across all operations, edge operands and error cases;", items_sent);
      $display("checked %0d results with random stalls on both sides.", results_seen);
      if (errors == 0 && pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
